FILE: hdl/pbr_pkg.sv
// Shared types and constants of the PackBits run-length encoder.
// Used by pbr_packer and packbits_rle_encoder_unit; depends on nothing.
package pbr_pkg;

  localparam int unsigned MAX_PACKET_DEF = 128;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned WORD_BYTES     = 8;
  localparam int unsigned WORD_W         = WORD_BYTES * BYTE_W;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned IN_TDATA_W     = 8;
  localparam int unsigned OUT_TDATA_W    = 72;
  localparam int unsigned OUT_TUSER_W    = 1;

  // one coded byte, or the close of an item's code, toward the packer
  typedef struct packed {
    logic              push;
    logic              fin;
    logic              line_end;
    logic [BYTE_W-1:0] data;
  } byte_op_t;

endpackage

FILE: hdl/packbits_rle_encoder_unit.sv
// PackBits run-length encoder, top level: sequencer, literal memory and packer.
// Depends on pbr_pkg and pbr_packer.
// One raw byte is taken per beat, tlast marking the last byte of a scanline. A byte
// that extends the pending bytes and closes no code is accepted, then closed; one that
// differs from them adds a load step to take their place, each pending byte moved into
// the literal buffer adds a step, a run packet adds its header and value, and a literal
// packet adds its header, then one coded byte per cycle while the packer takes them,
// paced by the single read port of the literal memory (registered read). The input is
// held off while an item is at work; a stalled output holds the sequencer once the
// output register is full and the packer has a full word, or any bytes at an item's
// close. Results carry up to eight coded bytes, first byte lowest; tuser marks the last
// result of a beat, tlast of a line. The literal memory needs no clearing after reset.
module packbits_rle_encoder_unit #(
  parameter int unsigned MaxPacket = pbr_pkg::MAX_PACKET_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // data_byte [7:0]
  input  logic [pbr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // line_end
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // packed_bytes [63:0], byte_count [67:64], zero fill [71:68]
  output logic [pbr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // batch_last [0]
  output logic [pbr_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  // line_done
  output logic                              m_axis_tlast
);

  localparam int unsigned CntW = $clog2(MaxPacket + 1);
  localparam int unsigned IdxW = $clog2(MaxPacket);
  localparam int unsigned BW   = pbr_pkg::BYTE_W;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_CHECK    = 6'b000010,
    ST_RUN_HDR  = 6'b000100,
    ST_RUN_VAL  = 6'b001000,
    ST_LIT_HDR  = 6'b010000,
    ST_LIT_DATA = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [BW-1:0]      byte_q, byte_d;
  logic               le_q, le_d;
  logic               load_q, load_d;
  logic [CntW-1:0]    lit_cnt_q, lit_cnt_d;
  logic [BW-1:0]      run_val_q, run_val_d;
  logic [CntW-1:0]    run_cnt_q, run_cnt_d;
  logic               run_act_q, run_act_d;
  logic [IdxW-1:0]    idx_q, idx_d;

  logic [BW-1:0]      lit_mem [MaxPacket];
  logic [BW-1:0]      rdata_q;
  logic               mem_we;
  logic [IdxW-1:0]    rd_addr;

  pbr_pkg::byte_op_t  op;
  logic               op_ready;
  logic [BW-1:0]      in_byte;
  logic [CntW-1:0]    run_cnt_inc;
  logic               lit_last;

  assign in_byte       = s_axis_tdata[BW-1:0];
  assign run_cnt_inc   = run_cnt_q + 1'b1;
  assign lit_last      = (CntW'(idx_q) + 1'b1 == lit_cnt_q);
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    byte_d    = byte_q;
    le_d      = le_q;
    load_d    = load_q;
    lit_cnt_d = lit_cnt_q;
    run_val_d = run_val_q;
    run_cnt_d = run_cnt_q;
    run_act_d = run_act_q;
    idx_d     = idx_q;
    mem_we    = 1'b0;
    rd_addr   = '0;
    op        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          byte_d  = in_byte;
          le_d    = s_axis_tlast;
          load_d  = 1'b0;
          state_d = ST_CHECK;
          if (run_act_q) begin
            if (in_byte == run_val_q) begin
              run_cnt_d = run_cnt_inc;
            end else begin
              load_d = 1'b1;
            end
          end else if (run_cnt_q != '0 && in_byte == run_val_q) begin
            run_cnt_d = run_cnt_inc;
            if (run_cnt_inc >= CntW'(3)) begin
              run_act_d = 1'b1;
              if (lit_cnt_q != '0) begin
                state_d = ST_LIT_HDR;
              end
            end
          end else begin
            load_d = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        priority if (lit_cnt_q == CntW'(MaxPacket)) begin
          state_d = ST_LIT_HDR;
        end else if (run_act_q && run_cnt_q == CntW'(MaxPacket)) begin
          state_d = ST_RUN_HDR;
        end else if ((load_q || le_q) && run_act_q) begin
          state_d = ST_RUN_HDR;
        end else if ((load_q || le_q) && run_cnt_q != '0) begin
          // move one pending byte into the literal
          mem_we    = 1'b1;
          lit_cnt_d = lit_cnt_q + 1'b1;
          run_cnt_d = run_cnt_q - 1'b1;
        end else if (load_q) begin
          run_val_d = byte_q;
          run_cnt_d = CntW'(1);
          load_d    = 1'b0;
        end else if (le_q && lit_cnt_q != '0) begin
          state_d = ST_LIT_HDR;
        end else begin
          op.fin      = 1'b1;
          op.line_end = le_q;
          if (op_ready) begin
            le_d    = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      ST_RUN_HDR: begin
        op.push = 1'b1;
        op.data = BW'(1) - BW'(run_cnt_q);
        if (op_ready) begin
          state_d = ST_RUN_VAL;
        end
      end
      ST_RUN_VAL: begin
        op.push = 1'b1;
        op.data = run_val_q;
        if (op_ready) begin
          run_cnt_d = '0;
          run_act_d = 1'b0;
          state_d   = ST_CHECK;
        end
      end
      ST_LIT_HDR: begin
        op.push = 1'b1;
        op.data = BW'(lit_cnt_q) - BW'(1);
        if (op_ready) begin
          idx_d   = '0;
          state_d = ST_LIT_DATA;
        end
      end
      ST_LIT_DATA: begin
        op.push = 1'b1;
        op.data = rdata_q;
        rd_addr = (op_ready && !lit_last) ? idx_q + 1'b1 : idx_q;
        if (op_ready) begin
          if (lit_last) begin
            lit_cnt_d = '0;
            state_d   = ST_CHECK;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      le_q      <= 1'b0;
      load_q    <= 1'b0;
      lit_cnt_q <= '0;
      run_val_q <= '0;
      run_cnt_q <= '0;
      run_act_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      le_q      <= le_d;
      load_q    <= load_d;
      lit_cnt_q <= lit_cnt_d;
      run_val_q <= run_val_d;
      run_cnt_q <= run_cnt_d;
      run_act_q <= run_act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    idx_q  <= idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lit_mem[lit_cnt_q[IdxW-1:0]] <= run_val_q;
    end
    rdata_q <= lit_mem[rd_addr];
  end

  pbr_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .op_ready_o    (op_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_lit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_cnt_q <= CntW'(MaxPacket))
    else $error("literal count above packet limit");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_act_q |-> (run_cnt_q >= CntW'(3) && run_cnt_q <= CntW'(MaxPacket)))
    else $error("active run shorter than three bytes");

  a_idle_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && run_act_q) |-> (lit_cnt_q == '0))
    else $error("literal left behind an active run");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!load_q && !le_q && run_cnt_q < CntW'(MaxPacket)))
    else $error("item work left unfinished");

endmodule

FILE: hdl/pbr_packer.sv
// Gathers coded bytes into words of up to eight bytes behind an output register.
// Depends on pbr_pkg for the byte operation struct and the word constants.
module pbr_packer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pbr_pkg::byte_op_t                 op_i,
  output logic                              op_ready_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // packed_bytes [63:0], byte_count [67:64], zero fill [71:68]
  output logic [pbr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // batch_last [0]
  output logic [pbr_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  output logic                              m_axis_tlast
);

  logic [pbr_pkg::WORD_W-1:0] acc_q;
  logic [pbr_pkg::CNT_W-1:0]  acc_cnt_q, acc_cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic [pbr_pkg::WORD_W-1:0] out_data_q;
  logic [pbr_pkg::CNT_W-1:0]  out_cnt_q;
  logic                       out_line_q;
  logic                       out_last_q;

  logic       acc_full, acc_empty, out_free, fire, move;
  logic [2:0] lane;

  assign acc_full   = (acc_cnt_q == pbr_pkg::CNT_W'(pbr_pkg::WORD_BYTES));
  assign acc_empty  = (acc_cnt_q == '0);
  assign out_free   = !out_valid_q || m_axis_tready;
  assign lane       = acc_cnt_q[2:0];
  assign op_ready_o = op_i.fin ? (acc_empty || out_free) : (!acc_full || out_free);
  assign fire       = (op_i.push || op_i.fin) && op_ready_o;
  assign move       = fire && ((op_i.push && acc_full) || (op_i.fin && !acc_empty));

  always_comb begin
    acc_cnt_d = acc_cnt_q;
    if (fire && op_i.fin) begin
      acc_cnt_d = '0;
    end else if (fire && op_i.push) begin
      acc_cnt_d = (acc_full || acc_empty) ? pbr_pkg::CNT_W'(1) : acc_cnt_q + 1'b1;
    end
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_cnt_q   <= acc_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && op_i.push) begin
      if (acc_full || acc_empty) begin
        acc_q <= pbr_pkg::WORD_W'(op_i.data);
      end else begin
        acc_q[lane*pbr_pkg::BYTE_W +: pbr_pkg::BYTE_W] <= op_i.data;
      end
    end
    if (move) begin
      out_data_q <= acc_q;
      out_cnt_q  <= acc_cnt_q;
      out_line_q <= op_i.fin && op_i.line_end;
      out_last_q <= op_i.fin;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pbr_pkg::OUT_TDATA_W'({out_cnt_q, out_data_q});
  assign m_axis_tuser  = out_last_q;
  assign m_axis_tlast  = out_line_q;

  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_cnt_q <= pbr_pkg::CNT_W'(pbr_pkg::WORD_BYTES))
    else $error("packer fill count above a word");

  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cnt_q != '0))
    else $error("empty word presented");

  a_line_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_line_q) |-> out_last_q)
    else $error("line end word is not the last of its item");

  a_move_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> ($stable(out_data_q) && out_valid_q))
    else $error("waiting word overwritten");

endmodule
